// ===== src/visual_servo_speed_profile_defines.svh =====
// Assertion macros for the visual servo speed profile block
`ifndef VISUAL_SERVO_SPEED_PROFILE_DEFINES_SVH
`define VISUAL_SERVO_SPEED_PROFILE_DEFINES_SVH
`define VSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vsp assertion failed");
`define VSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vsp assertion failed");
`endif

// ===== src/vsp_pkg.sv =====
// Package: types, constants and tables of the visual servo speed profile block
`default_nettype none
package vsp_pkg;
    localparam int unsigned CordicStepsDef = 16;
    localparam int unsigned TableLen = 24;
    localparam logic [31:0] InvGain = 32'd652032874;

    typedef enum logic [1:0] {
        ST_MOVING = 2'd0,
        ST_REACHED = 2'd1,
        ST_LOST = 2'd2,
        ST_RSVD = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CFG_MAX_SPEED = 3'd0,
        CFG_MIN_SPEED = 3'd1,
        CFG_ACCEL = 3'd2,
        CFG_BRAKE = 3'd3,
        CFG_STEP_TIME = 3'd4,
        CFG_LOST = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic        cmd;
        logic [11:0] err_x;
        logic [11:0] err_y;
        logic        reading_ok;
        logic [31:0] frame_id;
        logic [15:0] grip_angle;
        logic [31:0] start_x;
        logic [31:0] start_y;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] delta_x;
        logic [23:0] delta_y;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [15:0] speed_now;
    } t_out;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
            5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
            5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
            5'd6: r = 32'd10680862;   5'd7: r = 32'd5340245;
            5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
            5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
            5'd14: r = 32'd41721;     5'd15: r = 32'd20860;
            5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
            5'd18: r = 32'd2607;      5'd19: r = 32'd1303;
            5'd20: r = 32'd651;       5'd21: r = 32'd325;
            5'd22: r = 32'd162;       5'd23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== src/vsp_if.sv =====
// Valid/ready stream interface carrying one payload
`default_nettype none
interface vsp_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/visual_servo_speed_profile.sv =====
// Top level: speed profile, frame tracking and CORDIC travel resolution
// A start item goes straight to the output register. A step item runs up to three serial
// products, then CORDIC vectoring and rotation unless it stops or is lost. The CORDIC step
// count is CORDIC_STEPS, capped at 24. Throughput: one item at a time; the serial multiplier
// and the shared CORDIC set it. A result register frees the unit once stored.
// Reset is synchronous, active low; it loads register defaults and clears state.
`default_nettype none
`include "visual_servo_speed_profile_defines.svh"
module visual_servo_speed_profile #(
    parameter int unsigned CORDIC_STEPS = vsp_pkg::CordicStepsDef
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    vsp_if.sink   s_in,
    vsp_if.source m_out
);
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001, S_MUL1 = 9'b000000010, S_MUL2 = 9'b000000100,
        S_MUL3 = 9'b000001000, S_DEC  = 9'b000010000, S_VEC  = 9'b000100000,
        S_ROT  = 9'b001000000, S_FIN  = 9'b010000000, S_OUT  = 9'b100000000
    } t_state;

    t_state r_st;
    vsp_pkg::t_in  r_in;
    vsp_pkg::t_out r_out;
    logic r_ov;

    logic [15:0] r_max, r_min, r_acc, r_tim;
    logic [10:0] r_brk;
    logic [7:0]  r_lost;
    logic [15:0] r_speed;
    logic        r_brake, r_first, r_reached;
    logic [7:0]  r_miss;
    logic [31:0] r_last;
    logic signed [31:0] r_px, r_py;

    logic [63:0] r_vt, r_at;
    logic signed [63:0] r_s;
    logic [1:0]  r_stat;
    logic        r_mv;

    logic        mul_go, mul_done;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic        cor_go, cor_vec, cor_done;
    logic [63:0] cor_x, cor_y, cox, coy;
    logic [31:0] cor_z, coz;

    vsp_sermul #(.AW(32), .BW(32)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_go), .i_a(mul_a), .i_b(mul_b),
        .o_done(mul_done), .o_p(mul_p));
    vsp_cordic #(.STEPS(CORDIC_STEPS), .W(64)) u_cor (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cor_go), .i_vec(cor_vec),
        .i_x(cor_x), .i_y(cor_y), .i_z(cor_z),
        .o_done(cor_done), .o_x(cox), .o_y(coy), .o_z(coz));

    assign s_in.ready = (r_st == S_IDLE);
    assign m_out.valid = r_ov;
    assign m_out.data = r_out;

    logic signed [12:0] ex, ey, aex, aey;
    logic signed [16:0] dv;
    logic signed [63:0] s_t, rx, ry;
    logic signed [32:0] sx, sy;
    logic [31:0] dir_w, rot_d;
    logic signed [31:0] rot_s;
    logic signed [23:0] dx, dy;
    logic [7:0] miss_n;

    function automatic logic signed [23:0] rnd24(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v + 64'sd536870912) >>> 30;
        if (t > 64'sd8388607) return 24'sh7fffff;
        if (t < -64'sd8388608) return 24'sh800000;
        return t[23:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        if (v > 33'sd2147483647) return 32'sh7fffffff;
        if (v < -33'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    always_comb begin
        ex = {r_in.err_x[11], r_in.err_x};
        ey = {r_in.err_y[11], r_in.err_y};
        aex = ex[12] ? -ex : ex;
        aey = ey[12] ? -ey : ey;
        dv = 17'((r_at + 64'h8000) >> 16);
        mul_go = 1'b0; mul_a = '0; mul_b = '0;
        case (r_st)
            S_IDLE: begin mul_a = {16'd0, r_speed}; mul_b = {16'd0, r_tim}; end
            S_MUL1: begin mul_a = {16'd0, r_acc}; mul_b = {16'd0, r_tim}; end
            S_MUL2: begin mul_a = mul_p[31:0]; mul_b = {16'd0, r_tim}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        mul_go = (s_in.valid && s_in.ready && s_in.data.cmd && s_in.data.reading_ok)
            || (mul_done && (r_st == S_MUL1 || r_st == S_MUL2));
        s_t = (r_s + 64'sd268435456) >>> 29;
        dir_w = ((ey == 0 && ex == 0) ? 32'h80000000 : coz) + {r_in.grip_angle, 16'd0};
        rot_d = dir_w;
        rot_s = s_t[31:0];
        if (dir_w[31] != dir_w[30]) begin
            rot_s = -s_t[31:0];
            rot_d = dir_w - 32'h80000000;
        end
        cor_go = 1'b0; cor_vec = 1'b0; cor_x = '0; cor_y = '0; cor_z = '0;
        if (r_st == S_DEC && r_mv) begin
            cor_go = 1'b1; cor_vec = 1'b1;
            cor_x = (-64'(ey)) <<< 16;
            cor_y = (-64'(ex)) <<< 16;
            if (ey > 0) begin
                cor_x = 64'(ey) <<< 16; cor_y = 64'(ex) <<< 16; cor_z = 32'h80000000;
            end
        end else if (r_st == S_VEC && cor_done) begin
            cor_go = 1'b1;
            cor_x = rot_s * $signed(vsp_pkg::InvGain);
            cor_z = rot_d;
        end
        rx = $signed(cox); ry = $signed(coy);
        dx = rnd24(rx); dy = rnd24(ry);
        sx = 33'(r_px) + 33'(dx); sy = 33'(r_py) + 33'(dy);
        miss_n = r_miss;
        if (r_first) miss_n = '0;
        else if (r_last == r_in.frame_id) miss_n = (r_miss == 8'hff) ? r_miss : r_miss + 1'b1;
        else miss_n = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ov <= 1'b0;
            r_max <= 16'd6554; r_min <= 16'd655; r_acc <= 16'd13107;
            r_brk <= 11'd40; r_tim <= 16'd1311; r_lost <= 8'd10;
            r_speed <= '0; r_brake <= 1'b0; r_first <= 1'b1; r_reached <= 1'b0;
            r_miss <= '0; r_last <= '0; r_px <= '0; r_py <= '0;
        end else begin
            if (m_out.valid && m_out.ready && r_st != S_OUT) r_ov <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    vsp_pkg::CFG_MAX_SPEED: r_max <= i_cfg_data;
                    vsp_pkg::CFG_MIN_SPEED: r_min <= i_cfg_data;
                    vsp_pkg::CFG_ACCEL:     r_acc <= i_cfg_data;
                    vsp_pkg::CFG_BRAKE:     r_brk <= i_cfg_data[10:0];
                    vsp_pkg::CFG_STEP_TIME: r_tim <= i_cfg_data;
                    vsp_pkg::CFG_LOST:      r_lost <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            case (r_st)
                S_IDLE: if (s_in.valid) begin
                    r_in <= s_in.data;
                    r_s <= '0; r_stat <= vsp_pkg::ST_MOVING; r_mv <= s_in.data.cmd;
                    if (!s_in.data.cmd) begin
                        r_px <= $signed(s_in.data.start_x);
                        r_py <= $signed(s_in.data.start_y);
                        r_st <= S_OUT;
                    end else if (s_in.data.reading_ok) begin
                        r_st <= S_MUL1;
                    end else begin
                        r_first <= 1'b1;
                        r_st <= S_FIN;
                    end
                end
                S_MUL1: if (mul_done) begin r_vt <= mul_p; r_st <= S_MUL2; end
                S_MUL2: if (mul_done) begin r_at <= mul_p; r_st <= S_MUL3; end
                S_MUL3: if (mul_done) begin
                    if ((aex < 13'(r_brk) && aey < 13'(r_brk)) || r_brake) begin
                        if (r_speed <= r_min) begin
                            r_brake <= 1'b0; r_reached <= 1'b1;
                            r_stat <= vsp_pkg::ST_REACHED; r_mv <= 1'b0;
                            r_st <= S_OUT;
                        end else begin
                            r_brake <= 1'b1;
                            r_s <= $signed(r_vt << 17) - $signed(mul_p);
                            r_speed <= ($signed({1'b0, r_speed}) - dv < $signed({1'b0, r_min}))
                                ? r_min : 16'($signed({1'b0, r_speed}) - dv);
                            r_st <= S_FIN;
                        end
                    end else begin
                        if (r_speed < r_max) begin
                            r_s <= $signed(r_vt << 17) + $signed(mul_p);
                            r_speed <= (17'(r_speed) + 17'(dv) > 17'(r_max))
                                ? r_max : 16'(17'(r_speed) + 17'(dv));
                        end else begin
                            r_s <= $signed(r_vt << 17);
                        end
                        r_st <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_last <= r_in.frame_id;
                    if (miss_n > r_lost) begin
                        r_first <= 1'b1; r_miss <= '0;
                        r_stat <= vsp_pkg::ST_LOST; r_mv <= 1'b0;
                        r_st <= S_OUT;
                    end else begin
                        r_first <= 1'b0;
                        r_miss <= miss_n;
                        r_st <= S_DEC;
                    end
                end
                S_DEC: r_st <= S_VEC;
                S_VEC: if (cor_done) begin
                    r_st <= S_ROT;
                end
                S_ROT: if (cor_done) begin
                    r_px <= sat32(sx); r_py <= sat32(sy);
                    r_st <= S_OUT;
                end
                S_OUT: if (!r_ov || m_out.ready) begin
                    r_out.status <= r_stat;
                    r_out.delta_x <= r_mv ? dx : '0;
                    r_out.delta_y <= r_mv ? dy : '0;
                    r_out.pos_x <= r_px; r_out.pos_y <= r_py;
                    r_out.speed_now <= r_speed;
                    r_ov <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `VSP_ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, s_in.ready, r_st == S_IDLE)
    `VSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_ov && !m_out.ready, r_ov)
    `VSP_ASSERT_IMPL(a_stat_ok, i_clk, i_rst_n, r_ov, r_out.status != vsp_pkg::ST_RSVD)
endmodule
`default_nettype wire

// ===== src/vsp_sermul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle
`default_nettype none
module vsp_sermul #(
    parameter int unsigned AW = 32,
    parameter int unsigned BW = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [AW-1:0]        i_a,
    input  wire logic [BW-1:0]        i_b,
    output logic                      o_done,
    output logic [AW+BW-1:0]          o_p
);
    localparam int unsigned CW = $clog2(BW + 1);
    logic [AW+BW-1:0] r_acc, n_acc;
    logic [AW+BW-1:0] r_a;
    logic [BW-1:0]    r_b;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;

    always_comb begin
        n_acc = r_acc;
        if (r_b[0]) begin
            n_acc = r_acc + r_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= !i_start && r_busy && (r_cnt == CW'(BW - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(BW - 1)) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= (AW+BW)'(i_a);
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_a   <= {r_a[AW+BW-2:0], 1'b0};
            r_b   <= {1'b0, r_b[BW-1:1]};
        end
    end

    assign o_p = r_acc;
endmodule
`default_nettype wire

// ===== src/vsp_cordic.sv =====
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode
`default_nettype none
module vsp_cordic #(
    parameter int unsigned STEPS = 16,
    parameter int unsigned W = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_vec,
    input  wire logic [W-1:0]  i_x,
    input  wire logic [W-1:0]  i_y,
    input  wire logic [31:0]   i_z,
    output logic               o_done,
    output logic [W-1:0]       o_x,
    output logic [W-1:0]       o_y,
    output logic [31:0]        o_z
);
    localparam int unsigned N = (STEPS > vsp_pkg::TableLen) ? vsp_pkg::TableLen : STEPS;
    logic signed [W-1:0] r_x, r_y, n_x, n_y;
    logic [31:0] r_z, n_z;
    logic [4:0]  r_i;
    logic        r_busy, r_vec, pos;

    always_comb begin
        pos = r_vec ? ($signed(r_y) > 0) : !r_z[31];
        if (pos == r_vec) begin
            n_x = r_x + (r_y >>> r_i);
            n_y = r_y - (r_x >>> r_i);
        end else begin
            n_x = r_x - (r_y >>> r_i);
            n_y = r_y + (r_x >>> r_i);
        end
        if (pos) begin
            n_z = r_vec ? r_z + vsp_pkg::atan_turn(r_i) : r_z - vsp_pkg::atan_turn(r_i);
        end else begin
            n_z = r_vec ? r_z - vsp_pkg::atan_turn(r_i) : r_z + vsp_pkg::atan_turn(r_i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_i    <= '0;
        end else begin
            o_done <= !i_start && r_busy && (r_i == 5'(N - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == 5'(N - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x; r_y <= i_y; r_z <= i_z; r_vec <= i_vec;
        end else if (r_busy) begin
            r_x <= n_x; r_y <= n_y; r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule
`default_nettype wire

// ===== tb/sv/vsp_tb_pkg.sv =====
// Testbench package: behavioural model of the visual servo speed profile step
package vsp_tb_pkg;
    import vsp_pkg::*;

    typedef struct {
        logic [15:0] max_speed, min_speed, accel, step_time;
        logic [10:0] brake_distance;
        logic [7:0]  lost_limit;
    } servo_regs_t;

    typedef struct {
        logic [15:0] speed;
        logic        braking, fresh_track, reached;
        logic [7:0]  miss_count;
        logic [31:0] last_frame;
        logic signed [31:0] px, py;
    } servo_state_t;

    localparam int unsigned SERVO_ITERS = (CordicStepsDef > TableLen) ? TableLen : CordicStepsDef;

    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clamp24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic logic signed [31:0] add_sat32(logic signed [31:0] a, longint b);
        longint r;
        r = longint'(a) + b;
        if (r > 64'sd2147483647) return 32'sh7fffffff;
        if (r < -64'sd2147483648) return 32'sh80000000;
        return r[31:0];
    endfunction

    function automatic logic [31:0] heading_of(longint x0, longint y0);
        longint x, y, nx;
        logic [31:0] z;
        z = 0;
        if (x0 == 0 && y0 == 0) return 32'h80000000;
        x = x0 * 65536;
        y = y0 * 65536;
        if (x < 0) begin
            x = -x; y = -y; z = 32'h80000000;
        end
        for (int i = 0; i < SERVO_ITERS; i++) begin
            if (y > 0) begin
                nx = x + floor_shr(y, i); y = y - floor_shr(x, i); z = z + atan_turn(i[4:0]);
            end else begin
                nx = x - floor_shr(y, i); y = y + floor_shr(x, i); z = z - atan_turn(i[4:0]);
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic void resolve_travel(longint s, logic [31:0] d,
                                           output longint ox, output longint oy);
        longint x, y, nx, z;
        logic [31:0] q;
        y = 0;
        q = d + 32'h40000000;
        if (q[31]) begin
            s = -s;
            d = d - 32'h80000000;
        end
        z = longint'($signed(d));
        x = s * longint'(InvGain);
        for (int i = 0; i < SERVO_ITERS; i++) begin
            if (z >= 0) begin
                nx = x - floor_shr(y, i); y = y + floor_shr(x, i); z = z - longint'(atan_turn(i[4:0]));
            end else begin
                nx = x + floor_shr(y, i); y = y - floor_shr(x, i); z = z + longint'(atan_turn(i[4:0]));
            end
            x = nx;
        end
        ox = clamp24(floor_shr(x + (64'sd1 <<< 29), 30));
        oy = clamp24(floor_shr(y + (64'sd1 <<< 29), 30));
    endfunction

    function automatic t_out servo_step(ref servo_state_t st, input servo_regs_t rg,
                                        input t_in it);
        t_out o;
        longint ex, ey, aex, aey, s, dx, dy, t, vt, at, att, dv, nv, s49;
        logic stop;
        logic [1:0] status;
        status = ST_MOVING;
        dx = 0; dy = 0; s = 0; stop = 0;
        ex = longint'($signed(it.err_x));
        ey = longint'($signed(it.err_y));
        if (!it.cmd) begin
            st.px = it.start_x;
            st.py = it.start_y;
        end else begin
            if (it.reading_ok) begin
                t = rg.step_time;
                vt = longint'(st.speed) * t;
                at = longint'(rg.accel) * t;
                att = at * t;
                dv = (at + 32768) >>> 16;
                s49 = vt <<< 17;
                aex = ex < 0 ? -ex : ex;
                aey = ey < 0 ? -ey : ey;
                if (aex < longint'(rg.brake_distance) && aey < longint'(rg.brake_distance))
                    st.braking = 1;
                if (st.braking) begin
                    if (st.speed <= rg.min_speed) begin
                        st.braking = 0; st.reached = 1; status = ST_REACHED; stop = 1;
                    end else begin
                        s49 = s49 - att;
                        nv = longint'(st.speed) - dv;
                        if (nv < longint'(rg.min_speed)) nv = longint'(rg.min_speed);
                        st.speed = nv[15:0];
                    end
                end else if (st.speed < rg.max_speed) begin
                    s49 = s49 + att;
                    nv = longint'(st.speed) + dv;
                    if (nv > longint'(rg.max_speed)) nv = longint'(rg.max_speed);
                    st.speed = nv[15:0];
                end
                if (!stop) s = floor_shr(s49 + (64'sd1 <<< 28), 29);
            end else begin
                st.fresh_track = 1;
            end
            if (!stop) begin
                if (st.fresh_track) begin
                    st.fresh_track = 0; st.miss_count = 0;
                end else if (st.last_frame == it.frame_id) begin
                    if (st.miss_count < 255) st.miss_count++;
                end else begin
                    st.miss_count = 0;
                end
                st.last_frame = it.frame_id;
                if (st.miss_count > rg.lost_limit) begin
                    st.fresh_track = 1; st.miss_count = 0; status = ST_LOST;
                end else begin
                    resolve_travel(s, heading_of(-ey, -ex) + {it.grip_angle, 16'h0}, dx, dy);
                    st.px = add_sat32(st.px, dx);
                    st.py = add_sat32(st.py, dy);
                end
            end
        end
        o.status = status;
        o.delta_x = dx[23:0];
        o.delta_y = dy[23:0];
        o.pos_x = st.px;
        o.pos_y = st.py;
        o.speed_now = st.speed;
        return o;
    endfunction
endpackage

// ===== tb/sv/testbench.sv =====
// Testbench top: directed and random servo steps checked against a behavioural model
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import vsp_pkg::*;
    import vsp_tb_pkg::*;

    localparam int TIMEOUT_CYCLES = 2_000_000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [2:0] i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    vsp_if #(.T(t_in))  in_ch ();
    vsp_if #(.T(t_out)) out_ch ();

    visual_servo_speed_profile dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_in(in_ch.sink), .m_out(out_ch.source)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    servo_regs_t regs;
    servo_state_t model;
    t_out pending_results[$];
    int errors = 0, beats_in = 0, beats_out = 0, cycles = 0;
    int send_idle_pct = 0, recv_idle_pct = 0, hold_off = 0;
    int n_reached = 0, n_lost = 0;

    initial begin
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("beat %0d: %s got %0h want %0h", beats_out, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls plus a counted hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out want, got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            beats_out++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.status == ST_REACHED) n_reached++;
                if (got.status == ST_LOST) n_lost++;
                if (got.status !== want.status) report_mismatch("status", got.status, want.status);
                if (got.delta_x !== want.delta_x) report_mismatch("delta_x", got.delta_x, want.delta_x);
                if (got.delta_y !== want.delta_y) report_mismatch("delta_y", got.delta_y, want.delta_y);
                if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
                if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
                if (got.speed_now !== want.speed_now)
                    report_mismatch("speed_now", got.speed_now, want.speed_now);
            end
        end
    end

    task automatic send_beat(t_in it);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        in_ch.valid <= 1;
        in_ch.data <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(servo_step(model, regs, it));
        beats_in++;
        in_ch.valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
        case (idx)
            CFG_MAX_SPEED: regs.max_speed = val;
            CFG_MIN_SPEED: regs.min_speed = val;
            CFG_ACCEL:     regs.accel = val;
            CFG_BRAKE:     regs.brake_distance = val[10:0];
            CFG_STEP_TIME: regs.step_time = val;
            CFG_LOST:      regs.lost_limit = val[7:0];
            default: ;
        endcase
    endtask

    function automatic t_in make_step(int ex, int ey, logic ok, logic [31:0] fr, logic [15:0] ga);
        t_in it;
        it = '0;
        it.cmd = 1;
        it.err_x = ex[11:0];
        it.err_y = ey[11:0];
        it.reading_ok = ok;
        it.frame_id = fr;
        it.grip_angle = ga;
        it.start_x = $urandom;
        it.start_y = $urandom;
        return it;
    endfunction

    function automatic t_in make_start(logic [31:0] x, logic [31:0] y);
        t_in it;
        it = make_step($urandom_range(4095), $urandom_range(4095), $urandom_range(1),
                       $urandom, $urandom);
        it.cmd = 0;
        it.start_x = x;
        it.start_y = y;
        return it;
    endfunction

    function automatic t_in rand_step(int far_pct, logic [31:0] fr);
        int ex, ey;
        if ($urandom_range(99) < far_pct) begin
            ex = $urandom_range(4095) - 2048;
            ey = $urandom_range(4095) - 2048;
        end else begin
            ex = $urandom_range(160) - 80;
            ey = $urandom_range(160) - 80;
        end
        return make_step(ex, ey, $urandom_range(99) < 92, fr, $urandom);
    endfunction

    task automatic test_directed();
        send_beat(make_start(32'h0, 32'h0));
        send_beat(make_step(2047, -2048, 1, 1, 16'h0000));
        send_beat(make_step(-2048, 2047, 1, 2, 16'h7fff));
        send_beat(make_step(0, 0, 1, 3, 16'h8000));
        send_beat(make_step(500, 500, 0, 4, 16'h4000));
        send_beat(make_step(-1000, 300, 1, 5, 16'hffff));
        send_beat(make_step(3, -3, 1, 6, 16'h1234));
        for (int i = 0; i < 6; i++) send_beat(make_step(1, 1, 1, 7 + i, 16'h0));
        send_beat(make_step(1, 1, 1, 20, 16'h0));
        send_beat(make_start(32'h7fffff00, 32'h80000100));
        for (int i = 0; i < 3; i++) send_beat(make_step(-2048, -2048, 1, 30 + i, 16'hc000));
        for (int i = 0; i < 4; i++) send_beat(make_step(900, 900, 1, 40, 16'h2000));
        send_beat(make_start(32'hffffffff, 32'h7fffffff));
        drain();
    endtask

    task automatic test_extremes();
        write_reg(CFG_MAX_SPEED, 16'hffff);
        write_reg(CFG_ACCEL, 16'hffff);
        write_reg(CFG_STEP_TIME, 16'hffff);
        write_reg(CFG_MIN_SPEED, 16'h0);
        write_reg(CFG_BRAKE, 16'h7ff);
        write_reg(CFG_LOST, 16'h0);
        send_beat(make_start(32'h0, 32'h0));
        for (int i = 0; i < 8; i++) send_beat(make_step(2047, 100, 1, i, $urandom));
        for (int i = 0; i < 4; i++) send_beat(make_step(-5, 7, 1, 9, $urandom));
        drain();
        write_reg(CFG_STEP_TIME, 16'h0);
        write_reg(CFG_BRAKE, 16'h0);
        write_reg(CFG_LOST, 16'hff);
        for (int i = 0; i < 4; i++) send_beat(make_step(-2048, 2047, 1, 50 + i, $urandom));
        drain();
        // held speed above a lowered limit
        write_reg(CFG_STEP_TIME, 16'd1311);
        write_reg(CFG_MAX_SPEED, 16'd10);
        for (int i = 0; i < 3; i++) send_beat(make_step(1500, -700, 1, 60 + i, $urandom));
        drain();
        // deceleration beyond 2v/t moves backwards
        write_reg(CFG_ACCEL, 16'hffff);
        write_reg(CFG_STEP_TIME, 16'd40000);
        write_reg(CFG_MIN_SPEED, 16'd1);
        write_reg(CFG_BRAKE, 16'd100);
        for (int i = 0; i < 3; i++) send_beat(make_step(5, 5, 1, 70 + i, $urandom));
        drain();
    endtask

    task automatic random_phase(int n);
        logic [31:0] fr;
        fr = $urandom;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 4) begin
                send_beat(make_start($urandom, $urandom));
            end else begin
                if ($urandom_range(99) < 70) fr = fr + 1;
                else if ($urandom_range(99) < 10) fr = $urandom;
                send_beat(rand_step($urandom_range(99) < 60 ? 80 : 20, fr));
            end
        end
        drain();
    endtask

    task automatic randomise_regs(logic extreme);
        write_reg(CFG_MAX_SPEED, extreme ? 16'hffff : 16'($urandom_range(20000, 1000)));
        write_reg(CFG_MIN_SPEED, extreme ? 16'h0 : 16'($urandom_range(900, 100)));
        write_reg(CFG_ACCEL, extreme ? 16'hffff : 16'($urandom_range(30000, 1000)));
        write_reg(CFG_BRAKE, extreme ? 16'h7ff : 16'($urandom_range(120, 10)));
        write_reg(CFG_STEP_TIME, extreme ? 16'd1 : 16'($urandom_range(3000, 200)));
        write_reg(CFG_LOST, extreme ? 16'hff : 16'($urandom_range(4, 0)));
    endtask

    task automatic test_random();
        send_idle_pct = 27; recv_idle_pct = 49;
        randomise_regs(0);
        random_phase(110);
        send_idle_pct = 49; recv_idle_pct = 27;
        randomise_regs(1);
        random_phase(50);
        randomise_regs(0);
        random_phase(70);
        send_idle_pct = 0; recv_idle_pct = 0;
        randomise_regs(0);
        random_phase(120);
    endtask

    task automatic test_backpressure();
        hold_off = 1500;
        for (int i = 0; i < 6; i++) send_beat(rand_step(90, 500 + i));
        drain();
    endtask

    initial begin
        regs = '{max_speed: 6554, min_speed: 655, accel: 13107, step_time: 1311,
                 brake_distance: 40, lost_limit: 10};
        model = '{speed: 0, braking: 0, fresh_track: 1, reached: 0, miss_count: 0,
                  last_frame: 0, px: 0, py: 0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_extremes();
        test_backpressure();
        test_random();
        $display("%0d items in, %0d results checked, %0d reached stops, %0d lost stops",
                 beats_in, beats_out, n_reached, n_lost);
        $display("register extremes, idle mixes and a long output stall were exercised");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
